/* rtl/core/wtpf_pkg.sv */
// ----------------------------------------------------------------------------
// wtpf_pkg
// Shared types and constants for the paragraph action filter.
// ----------------------------------------------------------------------------
package wtpf_pkg;

  localparam int unsigned CHAR_W    = 16;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned PARA_LIMIT = 32767;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_DASH    = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_SHY     = 16'h00AD;
  localparam logic [CHAR_W-1:0] CH_ROW     = 16'h001E;
  localparam logic [CHAR_W-1:0] CH_CELL    = 16'h001C;
  localparam logic [CHAR_W-1:0] CH_BOM     = 16'hFEFF;

  localparam logic [4:0] CC_LINK_MARK = 5'h01;
  localparam logic [4:0] CC_SKIP      = 5'h02;
  localparam logic [4:0] CC_BELL      = 5'h07;
  localparam logic [4:0] CC_TAB       = 5'h09;
  localparam logic [4:0] CC_VT        = 5'h0B;
  localparam logic [4:0] CC_FF        = 5'h0C;
  localparam logic [4:0] CC_CR        = 5'h0D;
  localparam logic [4:0] CC_LINK_ON   = 5'h13;
  localparam logic [4:0] CC_LINK_OFF  = 5'h14;
  localparam logic [4:0] CC_LINK_END  = 5'h15;
  localparam logic [4:0] CC_HYPHEN    = 5'h1E;
  localparam logic [4:0] CC_SOFT      = 5'h1F;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_DISCARD = 2'd1,
    ACT_COMMIT  = 2'd2
  } action_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              stream_last;
  } in_word_t;

  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
  } out_word_t;

  typedef struct packed {
    logic              pre_ok;
    logic [CHAR_W-1:0] pre_char;
    logic              main_ok;
    logic              main_discard;
    logic [CHAR_W-1:0] main_char;
    logic              commit_ok;
  } entry_t;

endpackage

/* rtl/core/word_text_paragraph_filter_core.sv */
// ----------------------------------------------------------------------------
// word_text_paragraph_filter_core
// Turns document characters into paragraph builder actions.
// ----------------------------------------------------------------------------
// The char channel takes one 16-bit character per word, with a flag on the
// final character of the stream. The act channel gives one action per word:
// append a character, discard the paragraph so far, or commit it, with
// run_last set on the last action caused by a character.
// A character is accepted in any cycle in which the entry queue has room, and
// it causes zero to three actions. Its entry is registered in the queue and
// each action is then loaded into an output register. The act channel
// delivers one action per cycle while the receiver takes them, so a stream of
// characters that each cause one action runs at one word per cycle.
// A four-entry queue separates the classifier from the action sequencer, so
// a stalled receiver fills the queue first and only then holds char_ready low.
// Reset clears the pending bell, the hyperlink flag, the paragraph length and
// the queue, and drops any action not yet taken.
// ----------------------------------------------------------------------------
module word_text_paragraph_filter_core import wtpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_ready,
  input  in_word_t  char_word,
  output logic      act_valid,
  input  logic      act_ready,
  output out_word_t act_word
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_in;
  entry_t q_head;

  wtpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  wtpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  wtpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .act_valid  (act_valid),
    .act_ready  (act_ready),
    .act_word   (act_word)
  );

endmodule

/* rtl/core/wtpf_front.sv */
// ----------------------------------------------------------------------------
// wtpf_front
// Accepts characters, classifies them and tracks paragraph state.
// ----------------------------------------------------------------------------
module wtpf_front import wtpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_ready,
  input  in_word_t char_word,
  input  logic     q_full,
  output logic     q_push,
  output entry_t   q_entry
);

  logic              tab_pending, tab_pending_next;
  logic              in_hyperlink, in_hyperlink_next;
  logic [LEN_W-2:0]  para_length, para_length_next;

  logic              row_mark;
  logic              is_ctrl;
  logic              main_app, main_disc;
  logic [CHAR_W-1:0] main_char;
  logic [LEN_W-1:0]  len1, len2;
  logic              para_end;
  logic              accept;

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;

  always_comb begin
    row_mark          = tab_pending && (char_word.ch == {11'd0, CC_BELL});
    is_ctrl           = (char_word.ch[CHAR_W-1:5] == '0);
    main_app          = 1'b0;
    main_disc         = 1'b0;
    main_char         = char_word.ch;
    tab_pending_next  = 1'b0;
    in_hyperlink_next = in_hyperlink;

    if (!row_mark) begin
      if (is_ctrl) begin
        unique case (char_word.ch[4:0]) inside
          CC_BELL: begin
            tab_pending_next = 1'b1;
          end
          CC_CR, CC_VT: begin
            main_app  = 1'b1;
            main_char = CH_NEWLINE;
          end
          CC_FF, CC_TAB: begin
            main_app = 1'b1;
          end
          CC_HYPHEN: begin
            main_app  = 1'b1;
            main_char = CH_DASH;
          end
          CC_SOFT: begin
            main_app  = 1'b1;
            main_char = CH_SHY;
          end
          CC_SKIP: begin
          end
          CC_LINK_ON: begin
            in_hyperlink_next = 1'b1;
            main_app          = 1'b1;
            main_char         = CH_SPACE;
          end
          CC_LINK_OFF: begin
            in_hyperlink_next = 1'b0;
            main_app          = 1'b1;
            main_char         = CH_SPACE;
          end
          CC_LINK_END: begin
            main_app  = 1'b1;
            main_char = CH_SPACE;
          end
          CC_LINK_MARK: begin
            main_disc = !in_hyperlink;
          end
          default: begin
            main_disc = 1'b1;
          end
        endcase
      end else if (char_word.ch != CH_BOM) begin
        main_app = 1'b1;
      end
    end

    len1 = {1'b0, para_length} + {{(LEN_W-1){1'b0}}, tab_pending};
    if (main_disc) begin
      len2 = '0;
    end else begin
      len2 = len1 + {{(LEN_W-1){1'b0}}, main_app};
    end

    para_end = char_word.stream_last || (main_app && (main_char == CH_NEWLINE)) ||
               (len2 >= LEN_W'(PARA_LIMIT));

    if (para_end) begin
      para_length_next = '0;
    end else begin
      para_length_next = len2[LEN_W-2:0];
    end
    if (char_word.stream_last) begin
      tab_pending_next  = 1'b0;
      in_hyperlink_next = 1'b0;
    end

    q_entry.pre_ok       = tab_pending;
    q_entry.pre_char     = row_mark ? CH_ROW : CH_CELL;
    q_entry.main_ok      = main_app || main_disc;
    q_entry.main_discard = main_disc;
    q_entry.main_char    = main_char;
    q_entry.commit_ok    = para_end && (len2 >= LEN_W'(2));
    q_push = accept && (q_entry.pre_ok || q_entry.main_ok || q_entry.commit_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_pending  <= 1'b0;
      in_hyperlink <= 1'b0;
      para_length  <= '0;
    end else if (accept) begin
      tab_pending  <= tab_pending_next;
      in_hyperlink <= in_hyperlink_next;
      para_length  <= para_length_next;
    end
  end

endmodule

/* rtl/core/wtpf_queue.sv */
// ----------------------------------------------------------------------------
// wtpf_queue
// Short first-in first-out queue of classified entries.
// ----------------------------------------------------------------------------
module wtpf_queue import wtpf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   nonempty,
  output entry_t head
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/wtpf_back.sv */
// ----------------------------------------------------------------------------
// wtpf_back
// Expands each queued entry into its actions, one per cycle while the
// receiver takes them, into an output register.
// ----------------------------------------------------------------------------
module wtpf_back import wtpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  entry_t    q_head,
  output logic      q_pop,
  output logic      act_valid,
  input  logic      act_ready,
  output out_word_t act_word
);

  logic [2:0] done, done_next;
  logic [2:0] pend;
  logic [2:0] pick;
  logic       load;
  logic       is_last;
  out_word_t  word_next;

  always_comb begin
    pend = {q_head.commit_ok, q_head.main_ok, q_head.pre_ok} & ~done;
    if (pend[0]) begin
      pick = 3'b001;
    end else if (pend[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
    is_last = (pend == pick);
    load    = q_nonempty && (!act_valid || act_ready);
    q_pop   = load && is_last;

    if (pick[0]) begin
      word_next.action   = ACT_APPEND;
      word_next.out_char = q_head.pre_char;
    end else if (pick[1]) begin
      word_next.action   = q_head.main_discard ? ACT_DISCARD : ACT_APPEND;
      word_next.out_char = q_head.main_discard ? '0 : q_head.main_char;
    end else begin
      word_next.action   = ACT_COMMIT;
      word_next.out_char = '0;
    end
    word_next.run_last = is_last;

    done_next = done;
    if (load) begin
      done_next = is_last ? 3'b000 : (done | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      done      <= '0;
    end else begin
      done <= done_next;
      if (load) begin
        act_valid <= 1'b1;
      end else if (act_ready) begin
        act_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_word <= word_next;
    end
  end

endmodule

/* dv/word_text_paragraph_filter_core_tb.sv */
// ----------------------------------------------------------------------------
// word_text_paragraph_filter_core_tb
// Self-checking bench for the paragraph action filter.
// ----------------------------------------------------------------------------
// A short table of characters covers every control code and the stream end.
// Random text follows under three idling patterns, with one long receiver
// stall. Each action word is checked against the table's words for typed
// probes, else against a model of the filter that runs alongside the block.
// ----------------------------------------------------------------------------
module word_text_paragraph_filter_core_tb;
  import wtpf_pkg::*;

  localparam int PERIOD = 8;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int TEXT_PER_PHASE = 170;
  localparam int HOLD_CYCLES = 80;
  localparam out_word_t NO_WORD = '0;

  typedef struct packed {
    in_word_t   stim;
    logic       typed;
    logic [1:0] n_typed;
    out_word_t  first;
    out_word_t  second;
  } probe_t;

  localparam probe_t PROBES [25] = '{
    '{'{16'hFFFF, 1'b0}, 1'b1, 2'd1, '{ACT_APPEND, 16'hFFFF, 1'b1}, NO_WORD},
    '{'{16'h0000, 1'b0}, 1'b1, 2'd1, '{ACT_DISCARD, 16'h0000, 1'b1}, NO_WORD},
    '{'{16'h0001, 1'b0}, 1'b1, 2'd1, '{ACT_DISCARD, 16'h0000, 1'b1}, NO_WORD},
    '{'{16'h0020, 1'b0}, 1'b1, 2'd1, '{ACT_APPEND, 16'h0020, 1'b1}, NO_WORD},
    '{'{16'h000D, 1'b0}, 1'b1, 2'd2, '{ACT_APPEND, 16'h000A, 1'b0},
      '{ACT_COMMIT, 16'h0000, 1'b1}},
    '{'{16'h000B, 1'b0}, 1'b1, 2'd1, '{ACT_APPEND, 16'h000A, 1'b1}, NO_WORD},
    '{'{16'h0013, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0001, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0014, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0015, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h001E, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h001F, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0009, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h000C, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0002, 1'b0}, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{'{16'hFEFF, 1'b0}, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0007, 1'b0}, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0007, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0007, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0041, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0007, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0003, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h0007, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h000D, 1'b0}, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{'{16'h8000, 1'b1}, 1'b0, 2'd0, NO_WORD, NO_WORD}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_ready;
  in_word_t  char_word = '0;
  logic      act_valid;
  logic      act_ready = 1'b0;
  out_word_t act_word;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;

  logic        bell_wait = 1'b0;
  logic        link_open = 1'b0;
  logic        newline_last = 1'b0;
  int unsigned para_len = 0;
  out_word_t   step_actions [$];
  out_word_t   pending_actions [$];

  word_text_paragraph_filter_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .act_valid  (act_valid),
    .act_ready  (act_ready),
    .act_word   (act_word)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic logic [CHAR_W-1:0] ctrl_char(input logic [4:0] code);
    return {11'd0, code};
  endfunction

  function automatic void emit_action(input action_t act, input logic [CHAR_W-1:0] c);
    out_word_t w;
    w.action   = act;
    w.out_char = c;
    w.run_last = 1'b0;
    step_actions.push_back(w);
  endfunction

  function automatic void append_char(input logic [CHAR_W-1:0] c);
    emit_action(ACT_APPEND, c);
    para_len++;
    newline_last = (c == CH_NEWLINE);
  endfunction

  function automatic void discard_paragraph();
    emit_action(ACT_DISCARD, '0);
    para_len = 0;
    newline_last = 1'b0;
  endfunction

  function automatic void predict_actions(input in_word_t w);
    logic [CHAR_W-1:0] c;
    logic              row_done;
    out_word_t         tail;
    c = w.ch;
    row_done = 1'b0;
    newline_last = 1'b0;
    step_actions.delete();
    if (bell_wait) begin
      bell_wait = 1'b0;
      if (c == ctrl_char(CC_BELL)) begin
        append_char(CH_ROW);
        row_done = 1'b1;
      end else begin
        append_char(CH_CELL);
      end
    end
    if (!row_done) begin
      if (c < CH_SPACE) begin
        case (c[4:0])
          CC_BELL: bell_wait = 1'b1;
          CC_CR, CC_VT: append_char(CH_NEWLINE);
          CC_FF, CC_TAB: append_char(c);
          CC_HYPHEN: append_char(CH_DASH);
          CC_SOFT: append_char(CH_SHY);
          CC_SKIP: ;
          CC_LINK_ON: begin
            link_open = 1'b1;
            append_char(CH_SPACE);
          end
          CC_LINK_OFF: begin
            link_open = 1'b0;
            append_char(CH_SPACE);
          end
          CC_LINK_END: append_char(CH_SPACE);
          CC_LINK_MARK: begin
            if (!link_open) begin
              discard_paragraph();
            end
          end
          default: discard_paragraph();
        endcase
      end else if (c != CH_BOM) begin
        append_char(c);
      end
    end
    if (w.stream_last || newline_last || para_len >= PARA_LIMIT) begin
      if (para_len >= 2) begin
        emit_action(ACT_COMMIT, '0);
      end
      para_len = 0;
    end
    if (w.stream_last) begin
      bell_wait = 1'b0;
      link_open = 1'b0;
    end
    if (step_actions.size() > 0) begin
      tail = step_actions.pop_back();
      tail.run_last = 1'b1;
      step_actions.push_back(tail);
    end
  endfunction

  function automatic in_word_t random_char();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      w.ch = CHAR_W'($urandom_range(32'hFFFF, 32'h0020));
    end else if (pick < 52) begin
      w.ch = CHAR_W'($urandom_range(32'h007A, 32'h0061));
    end else if (pick < 60) begin
      w.ch = ctrl_char(CC_CR);
    end else if (pick < 70) begin
      w.ch = ctrl_char(CC_BELL);
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: w.ch = ctrl_char(CC_LINK_ON);
        1: w.ch = ctrl_char(CC_LINK_OFF);
        2: w.ch = ctrl_char(CC_LINK_END);
        default: w.ch = ctrl_char(CC_LINK_MARK);
      endcase
    end else if (pick < 83) begin
      w.ch = CH_BOM;
    end else begin
      w.ch = CHAR_W'($urandom_range(31));
    end
    w.stream_last = ($urandom_range(99) < 3);
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_char(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    @(posedge clk);
    while (!char_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic offer_char(input in_word_t w);
    send_char(w);
    predict_actions(w);
    foreach (step_actions[i]) begin
      pending_actions.push_back(step_actions[i]);
    end
  endtask

  task automatic drain_actions();
    @(negedge clk);
    char_valid <= 1'b0;
    while (pending_actions.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      act_ready <= 1'b0;
    end else begin
      act_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && act_valid && act_ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected action %0d char %h last %b",
                                  act_word.action, act_word.out_char, act_word.run_last));
      end else begin
        want = pending_actions.pop_front();
        if (act_word.action !== want.action) begin
          report_mismatch($sformatf("action %0d, wanted %0d", act_word.action, want.action));
        end
        if (act_word.out_char !== want.out_char) begin
          report_mismatch($sformatf("out_char %h, wanted %h", act_word.out_char,
                                    want.out_char));
        end
        if (act_word.run_last !== want.run_last) begin
          report_mismatch($sformatf("run_last %b, wanted %b", act_word.run_last,
                                    want.run_last));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * PERIOD);
    $display("word_text_paragraph_filter_core verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 17 : 0;
      if (ph == 0) begin
        foreach (PROBES[i]) begin
          send_char(PROBES[i].stim);
          predict_actions(PROBES[i].stim);
          if (PROBES[i].typed) begin
            if (PROBES[i].n_typed > 0) begin
              pending_actions.push_back(PROBES[i].first);
            end
            if (PROBES[i].n_typed > 1) begin
              pending_actions.push_back(PROBES[i].second);
            end
          end else begin
            foreach (step_actions[j]) begin
              pending_actions.push_back(step_actions[j]);
            end
          end
        end
      end
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      repeat (TEXT_PER_PHASE) begin
        offer_char(random_char());
      end
      drain_actions();
    end

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("word_text_paragraph_filter_core verification clean");
    end else begin
      $display("word_text_paragraph_filter_core verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/wtpf_pkg.sv
rtl/core/wtpf_front.sv
rtl/core/wtpf_queue.sv
rtl/core/wtpf_back.sv
rtl/core/word_text_paragraph_filter_core.sv
dv/word_text_paragraph_filter_core_tb.sv
